// ===== rtl/afc_pkg.sv =====
// Shared types and constants of the acknowledgement frame checker.
package afc_pkg;

  // Fixed frame layout.
  localparam int unsigned HEAD_TAIL_COUNT = 3;
  localparam int unsigned CFG_COUNT       = 5;
  localparam int unsigned SHORT_REPLY_LEN = 1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_ORDER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIG_MARKER = 3'd4;

  // Configuration register reset values.
  localparam logic [7:0] HEAD_BYTE_RESET     = 8'hAA;
  localparam logic [7:0] TAIL_BYTE_RESET     = 8'h55;
  localparam logic [7:0] REPLY_ORDER_RESET   = 8'h00;
  localparam logic [7:0] ACK_CODE_RESET      = 8'h00;
  localparam logic [7:0] CONFIG_MARKER_RESET = 8'h03;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_REJECTED  = 2'd0,
    STATUS_ACK       = 2'd1,
    STATUS_NO_CONFIG = 2'd2,
    STATUS_CONFIG    = 2'd3
  } afc_status_e;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_HEAD  = 3'd0,
    PH_SEQ   = 3'd1,
    PH_ORDER = 3'd2,
    PH_LEN   = 3'd3,
    PH_PAY   = 3'd4,
    PH_CHECK = 3'd5,
    PH_TAIL  = 3'd6,
    PH_DONE  = 3'd7
  } afc_phase_e;

endpackage

// ===== rtl/ack_frame_checker_core.sv =====
// Byte-wise parser and judge of acknowledgement reply frames.
// A result appears on the master side in the cycle after the beat marked last.
// Throughput: one byte per cycle while no result waits untaken; the parser state
// updates in the accepting cycle and a single output register holds the result.
// Reset: asynchronous, active low; clears parser, expected sequence, output valid
// and restores the configuration registers to their defaults.
module ack_frame_checker_core #(
  parameter int unsigned CONFIG_REPLY_LEN = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
  input  logic                          s_axis_tlast,   // last_byte
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [55:0]                   m_axis_tdata,   // cfg_byte0..4, next_sequence
  output logic [1:0]                    m_axis_tuser,   // [1:0] status
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [afc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);
  import afc_pkg::*;

  // Number of config bytes a config reply can actually carry.
  localparam int unsigned CfgKeep =
      (CONFIG_REPLY_LEN - 1 < CFG_COUNT) ? CONFIG_REPLY_LEN - 1 : CFG_COUNT;

  // Configuration registers.
  logic [7:0] head_byte_q, tail_byte_q, reply_order_q, ack_code_q, config_marker_q;

  // Parser state.
  afc_phase_e  phase_q, phase_d;
  logic [15:0] byte_index_q, byte_index_d;
  logic [15:0] payload_len_q, payload_len_d;
  logic [7:0]  running_sum_q, running_sum_d;
  logic [15:0] rx_seq_q, rx_seq_d;
  logic [7:0]  rx_order_q, rx_order_d;
  logic [7:0]  first_pay_q, first_pay_d;
  logic [7:0]  rx_check_q, rx_check_d;
  logic        frame_bad_q, frame_bad_d;
  logic [7:0]  cfg_store_q [CfgKeep];
  logic [7:0]  cfg_store_d [CfgKeep];
  logic [15:0] exp_seq_q, exp_seq_d;

  // Output register.
  logic        out_valid_q;
  logic [55:0] out_data_q, out_data_d;
  logic [1:0]  out_user_q;
  afc_status_e status_d;

  logic        in_beat;
  logic        frame_ok;
  logic [7:0]  cfg_out [CFG_COUNT];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_byte_q     <= HEAD_BYTE_RESET;
      tail_byte_q     <= TAIL_BYTE_RESET;
      reply_order_q   <= REPLY_ORDER_RESET;
      ack_code_q      <= ACK_CODE_RESET;
      config_marker_q <= CONFIG_MARKER_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HEAD_BYTE:     head_byte_q     <= cfg_data_i;
        REG_TAIL_BYTE:     tail_byte_q     <= cfg_data_i;
        REG_REPLY_ORDER:   reply_order_q   <= cfg_data_i;
        REG_ACK_CODE:      ack_code_q      <= cfg_data_i;
        REG_CONFIG_MARKER: config_marker_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parser step for one byte, followed by the judgment on the last byte.
  always_comb begin
    phase_d       = phase_q;
    byte_index_d  = byte_index_q;
    payload_len_d = payload_len_q;
    running_sum_d = running_sum_q;
    rx_seq_d      = rx_seq_q;
    rx_order_d    = rx_order_q;
    first_pay_d   = first_pay_q;
    rx_check_d    = rx_check_q;
    frame_bad_d   = frame_bad_q;
    cfg_store_d   = cfg_store_q;
    exp_seq_d     = exp_seq_q;
    status_d      = STATUS_REJECTED;

    unique case (phase_q)
      PH_HEAD: begin
        if (s_axis_tdata != head_byte_q) frame_bad_d = 1'b1;
        if (byte_index_q == 16'(HEAD_TAIL_COUNT - 1)) begin
          phase_d      = PH_SEQ;
          byte_index_d = '0;
        end else begin
          byte_index_d = byte_index_q + 16'd1;
        end
      end
      PH_SEQ: begin
        running_sum_d = running_sum_q + s_axis_tdata;
        if (byte_index_q == '0) begin
          rx_seq_d     = {8'h00, s_axis_tdata};
          byte_index_d = 16'd1;
        end else begin
          rx_seq_d     = {s_axis_tdata, rx_seq_q[7:0]};
          phase_d      = PH_ORDER;
          byte_index_d = '0;
        end
      end
      PH_ORDER: begin
        running_sum_d = running_sum_q + s_axis_tdata;
        rx_order_d    = s_axis_tdata;
        phase_d       = PH_LEN;
      end
      PH_LEN: begin
        running_sum_d = running_sum_q + s_axis_tdata;
        if (byte_index_q == '0) begin
          payload_len_d = {8'h00, s_axis_tdata};
          byte_index_d  = 16'd1;
        end else begin
          payload_len_d = {s_axis_tdata, payload_len_q[7:0]};
          for (int k = 0; k < CfgKeep; k++) cfg_store_d[k] = 8'h00;
          phase_d       = (payload_len_d != '0) ? PH_PAY : PH_CHECK;
          byte_index_d  = '0;
        end
      end
      PH_PAY: begin
        running_sum_d = running_sum_q + s_axis_tdata;
        if (byte_index_q == '0) first_pay_d = s_axis_tdata;
        // Payload bytes one onward fill the config store.
        for (int k = 0; k < CfgKeep; k++) begin
          if (byte_index_q == 16'(k + 1)) cfg_store_d[k] = s_axis_tdata;
        end
        byte_index_d = byte_index_q + 16'd1;
        if (byte_index_d == payload_len_q) begin
          phase_d      = PH_CHECK;
          byte_index_d = '0;
        end
      end
      PH_CHECK: begin
        rx_check_d   = s_axis_tdata;
        phase_d      = PH_TAIL;
        byte_index_d = '0;
      end
      PH_TAIL: begin
        if (s_axis_tdata != tail_byte_q) frame_bad_d = 1'b1;
        if (byte_index_q == 16'(HEAD_TAIL_COUNT - 1)) begin
          phase_d      = PH_DONE;
          byte_index_d = '0;
        end else begin
          byte_index_d = byte_index_q + 16'd1;
        end
      end
      PH_DONE: begin
        // Anything after the third tail byte spoils the frame.
        frame_bad_d = 1'b1;
      end
      default: frame_bad_d = 1'b1;
    endcase

    frame_ok = (phase_d == PH_DONE) && !frame_bad_d && (rx_seq_d == exp_seq_q) &&
               (rx_order_d == reply_order_q) && (rx_check_d == running_sum_d);

    if (frame_ok && payload_len_d == 16'(SHORT_REPLY_LEN)) begin
      if (first_pay_d == ack_code_q) begin
        status_d  = STATUS_ACK;
        exp_seq_d = exp_seq_q + 16'd1;
      end
    end else if (frame_ok && payload_len_d == 16'(CONFIG_REPLY_LEN)) begin
      status_d  = (first_pay_d == config_marker_q) ? STATUS_CONFIG : STATUS_NO_CONFIG;
      exp_seq_d = exp_seq_q + 16'd1;
    end

    // The last byte returns the parser to the head field.
    if (s_axis_tlast) begin
      phase_d       = PH_HEAD;
      byte_index_d  = '0;
      payload_len_d = '0;
      running_sum_d = '0;
      rx_seq_d      = '0;
      rx_order_d    = '0;
      first_pay_d   = '0;
      rx_check_d    = '0;
      frame_bad_d   = 1'b0;
    end else begin
      exp_seq_d     = exp_seq_q;
    end
  end

  // Config bytes beyond what the reply length carries read as zero.
  for (genvar g = 0; g < CFG_COUNT; g++) begin : g_cfg_out
    if (g < CfgKeep) begin : g_kept
      assign cfg_out[g] = (status_d == STATUS_CONFIG) ? cfg_store_d[g] : 8'h00;
    end else begin : g_zero
      assign cfg_out[g] = 8'h00;
    end
  end

  assign out_data_d = {exp_seq_d, cfg_out[4], cfg_out[3], cfg_out[2], cfg_out[1], cfg_out[0]};

  // Parser and sequence state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HEAD;
      byte_index_q  <= '0;
      payload_len_q <= '0;
      running_sum_q <= '0;
      rx_seq_q      <= '0;
      rx_order_q    <= '0;
      first_pay_q   <= '0;
      rx_check_q    <= '0;
      frame_bad_q   <= 1'b0;
      exp_seq_q     <= '0;
    end else if (in_beat) begin
      phase_q       <= phase_d;
      byte_index_q  <= byte_index_d;
      payload_len_q <= payload_len_d;
      running_sum_q <= running_sum_d;
      rx_seq_q      <= rx_seq_d;
      rx_order_q    <= rx_order_d;
      first_pay_q   <= first_pay_d;
      rx_check_q    <= rx_check_d;
      frame_bad_q   <= frame_bad_d;
      exp_seq_q     <= exp_seq_d;
    end
  end

  // Config store holds payload only; it is cleared whenever a length field completes.
  always_ff @(posedge clk_i) begin
    if (in_beat) cfg_store_q <= cfg_store_d;
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_beat && s_axis_tlast) begin
      out_data_q <= out_data_d;
      out_user_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== rtl/afc_checker.sv =====
// Port-level checks of the acknowledgement frame checker, bound to its top level.
module afc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import afc_pkg::*;

  // A result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // A new result only follows an accepted last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("result beat without a last input beat");

  // With the output register empty, the input side is never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // Config bytes are zero unless the status reports received config.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STATUS_CONFIG) |-> (m_axis_tdata[39:0] == '0))
    else $error("config bytes shown without config status");

endmodule

bind ack_frame_checker_core afc_checker u_afc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== test/tb.sv =====
// Self-checking testbench for the acknowledgement frame checker core.
`timescale 1ns / 1ps

module tb;
  import afc_pkg::*;

  localparam int unsigned CFG_REPLY_LEN = 6;
  localparam int unsigned TOTAL_BEATS   = 1900;
  localparam int unsigned QUIET_BEATS   = 300;
  localparam int unsigned CHUNK_BEATS   = 180;

  // Register indexes that the block has no register behind.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Ways in which a generated frame can be damaged.
  typedef enum int {
    FLAW_NONE,
    FLAW_HEAD,
    FLAW_TAIL,
    FLAW_CSUM,
    FLAW_TAIL_CUT,
    FLAW_SHORT,
    FLAW_EXTRA
  } frame_flaw_e;

  // One judged frame as it should leave the block.
  typedef struct packed {
    afc_status_e                 status;
    logic [CFG_COUNT-1:0][7:0]   cfg;
    logic [15:0]                 next_seq;
  } verdict_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = 8'h00;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [55:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_HEAD_BYTE;
  logic [7:0]           cfg_data_i = 8'h00;

  ack_frame_checker_core #(
    .CONFIG_REPLY_LEN(CFG_REPLY_LEN)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Register copies kept by the predictor.
  logic [7:0] head_val, tail_val, order_val, ack_val, marker_val;

  // Parser state of the predictor.
  afc_phase_e                parse_phase;
  logic [15:0]               field_count;
  logic [15:0]               pay_len;
  logic [7:0]                csum;
  logic [15:0]               got_seq;
  logic [7:0]                got_order;
  logic [7:0]                got_first;
  logic [7:0]                got_check;
  logic                      frame_err;
  logic [CFG_COUNT-1:0][7:0] cfg_bytes;
  logic [15:0]               want_seq;

  verdict_t pending_verdicts[$];
  int       fail_count = 0;
  int       beats_sent = 0;
  int       gap_pct    = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void clear_parse();
    parse_phase = PH_HEAD;
    field_count = '0;
    pay_len     = '0;
    csum        = '0;
    got_seq     = '0;
    got_order   = '0;
    got_first   = '0;
    got_check   = '0;
    frame_err   = 1'b0;
  endfunction

  // Advance the predicted parser by one byte; on the last byte, queue the verdict.
  function automatic void judge_byte(input logic [7:0] b, input logic last);
    verdict_t v;
    logic     ok;
    case (parse_phase)
      PH_HEAD: begin
        if (b != head_val) frame_err = 1'b1;
        field_count++;
        if (field_count >= HEAD_TAIL_COUNT) begin
          parse_phase = PH_SEQ;
          field_count = '0;
        end
      end
      PH_SEQ: begin
        csum += b;
        if (field_count == 0) begin
          got_seq     = {8'h00, b};
          field_count = 16'd1;
        end else begin
          got_seq[15:8] = b;
          parse_phase   = PH_ORDER;
          field_count   = '0;
        end
      end
      PH_ORDER: begin
        csum += b;
        got_order   = b;
        parse_phase = PH_LEN;
      end
      PH_LEN: begin
        csum += b;
        if (field_count == 0) begin
          pay_len     = {8'h00, b};
          field_count = 16'd1;
        end else begin
          pay_len[15:8] = b;
          cfg_bytes     = '0;
          parse_phase   = (pay_len != 0) ? PH_PAY : PH_CHECK;
          field_count   = '0;
        end
      end
      PH_PAY: begin
        csum += b;
        if (field_count == 0) begin
          got_first = b;
        end else if (field_count <= CFG_COUNT && field_count < CFG_REPLY_LEN) begin
          cfg_bytes[field_count - 1] = b;
        end
        field_count++;
        if (field_count == pay_len) begin
          parse_phase = PH_CHECK;
          field_count = '0;
        end
      end
      PH_CHECK: begin
        got_check   = b;
        parse_phase = PH_TAIL;
        field_count = '0;
      end
      PH_TAIL: begin
        if (b != tail_val) frame_err = 1'b1;
        field_count++;
        if (field_count >= HEAD_TAIL_COUNT) begin
          parse_phase = PH_DONE;
          field_count = '0;
        end
      end
      default: begin
        // Anything after the third tail byte spoils the frame.
        frame_err = 1'b1;
      end
    endcase

    if (!last) return;

    ok = parse_phase == PH_DONE && !frame_err && got_seq == want_seq &&
         got_order == order_val && got_check == csum;
    v.status = STATUS_REJECTED;
    if (ok && pay_len == SHORT_REPLY_LEN) begin
      if (got_first == ack_val) begin
        v.status = STATUS_ACK;
        want_seq++;
      end
    end else if (ok && pay_len == CFG_REPLY_LEN) begin
      v.status = (got_first == marker_val) ? STATUS_CONFIG : STATUS_NO_CONFIG;
      want_seq++;
    end
    v.cfg      = (v.status == STATUS_CONFIG) ? cfg_bytes : '0;
    v.next_seq = want_seq;
    pending_verdicts.push_back(v);
    clear_parse();
  endfunction

  // Send one byte beat; called and returning at a falling edge.
  task automatic send_beat(input logic [7:0] data, input logic last);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    judge_byte(data, last);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every judged frame has come out.
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Register write over the configuration channel, only while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_HEAD_BYTE:     head_val   = data;
      REG_TAIL_BYTE:     tail_val   = data;
      REG_REPLY_ORDER:   order_val  = data;
      REG_ACK_CODE:      ack_val    = data;
      REG_CONFIG_MARKER: marker_val = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_all_regs(input logic [7:0] head, input logic [7:0] tail,
                                input logic [7:0] order, input logic [7:0] ack,
                                input logic [7:0] marker);
    write_reg(REG_HEAD_BYTE, head);
    write_reg(REG_TAIL_BYTE, tail);
    write_reg(REG_REPLY_ORDER, order);
    write_reg(REG_ACK_CODE, ack);
    write_reg(REG_CONFIG_MARKER, marker);
  endtask

  // Build one frame from the current register copies, damage it as asked, send it.
  task automatic send_frame(input logic [15:0] seq, input logic [7:0] order,
                            input logic [15:0] len, input logic [7:0] first,
                            input frame_flaw_e flaw);
    logic [7:0] fb[$];
    logic [7:0] sum;
    int         i;
    int         pos;
    sum = 8'h00;
    for (i = 0; i < HEAD_TAIL_COUNT; i++) fb.push_back(head_val);
    fb.push_back(seq[7:0]);
    fb.push_back(seq[15:8]);
    fb.push_back(order);
    fb.push_back(len[7:0]);
    fb.push_back(len[15:8]);
    for (i = 0; i < len; i++) fb.push_back((i == 0) ? first : 8'($urandom));
    for (i = HEAD_TAIL_COUNT; i < fb.size(); i++) sum += fb[i];
    fb.push_back(sum);
    for (i = 0; i < HEAD_TAIL_COUNT; i++) fb.push_back(tail_val);

    case (flaw)
      FLAW_HEAD: begin
        pos = $urandom_range(0, HEAD_TAIL_COUNT - 1);
        fb[pos] = fb[pos] ^ 8'($urandom_range(1, 255));
      end
      FLAW_TAIL: begin
        pos = fb.size() - 1 - $urandom_range(0, HEAD_TAIL_COUNT - 1);
        fb[pos] = fb[pos] ^ 8'($urandom_range(1, 255));
      end
      FLAW_CSUM: begin
        pos = fb.size() - 1 - HEAD_TAIL_COUNT;
        fb[pos] = fb[pos] + 8'($urandom_range(1, 255));
      end
      FLAW_TAIL_CUT: fb = fb[0:$-1];
      FLAW_SHORT: begin
        pos = $urandom_range(1, fb.size() - 1);
        fb = fb[0:pos-1];
      end
      FLAW_EXTRA: repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom));
      default: ;
    endcase

    for (i = 0; i < fb.size(); i++) send_beat(fb[i], i == fb.size() - 1);
  endtask

  // One frame of the random mix: mostly good replies, the rest faults and noise.
  task automatic send_random_frame();
    int          pick;
    int          n;
    logic [15:0] len;
    logic [7:0]  first;
    pick = $urandom_range(0, 99);
    len  = ($urandom_range(0, 1) != 0) ? 16'(CFG_REPLY_LEN) : 16'(SHORT_REPLY_LEN);
    if (len == SHORT_REPLY_LEN) begin
      first = ($urandom_range(0, 3) != 0) ? ack_val : 8'($urandom);
    end else begin
      first = ($urandom_range(0, 2) != 0) ? marker_val : 8'($urandom);
    end

    if (pick < 55) begin
      send_frame(want_seq, order_val, len, first, FLAW_NONE);
    end else if (pick < 61) begin
      send_frame(want_seq, order_val, 16'($urandom_range(0, 12)), first, FLAW_NONE);
    end else if (pick < 62) begin
      send_frame(want_seq, order_val, 16'($urandom_range(256, 300)), first, FLAW_NONE);
    end else if (pick < 66) begin
      send_frame(want_seq + 16'($urandom_range(1, 65535)), order_val, len, first, FLAW_NONE);
    end else if (pick < 70) begin
      send_frame(want_seq, order_val ^ 8'($urandom_range(1, 255)), len, first, FLAW_NONE);
    end else if (pick < 90) begin
      send_frame(want_seq, order_val, len, first,
                 frame_flaw_e'($urandom_range(int'(FLAW_HEAD), int'(FLAW_EXTRA))));
    end else begin
      // Line noise: a burst of random bytes closed by a last marker.
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) send_beat(8'($urandom), i == n - 1);
    end
  endtask

  // Reset values: ack, rejected ack, config reply with and without marker.
  task automatic test_default_registers();
    wait_results_done();
    send_frame(want_seq, order_val, 16'(SHORT_REPLY_LEN), ack_val, FLAW_NONE);
    send_frame(want_seq, order_val, 16'(SHORT_REPLY_LEN), ~ack_val, FLAW_NONE);
    send_frame(want_seq, order_val, 16'(CFG_REPLY_LEN), marker_val, FLAW_NONE);
    send_frame(want_seq, order_val, 16'(CFG_REPLY_LEN), marker_val ^ 8'h01, FLAW_NONE);
  endtask

  // Lengths outside 1 and 6, including ones whose low byte alone would pass.
  task automatic test_length_field();
    send_frame(want_seq, order_val, 16'd0, ack_val, FLAW_NONE);
    send_frame(want_seq, order_val, 16'd2, ack_val, FLAW_NONE);
    send_frame(want_seq, order_val, 16'd5, marker_val, FLAW_NONE);
    send_frame(want_seq, order_val, 16'h0101, ack_val, FLAW_NONE);
    send_frame(want_seq, order_val, 16'h0106, marker_val, FLAW_NONE);
  endtask

  // Each way a frame can be spoiled, plus a lone last byte.
  task automatic test_frame_faults();
    send_frame(want_seq, order_val, 16'(SHORT_REPLY_LEN), ack_val, FLAW_HEAD);
    send_frame(want_seq, order_val, 16'(CFG_REPLY_LEN), marker_val, FLAW_TAIL);
    send_frame(want_seq, order_val, 16'(SHORT_REPLY_LEN), ack_val, FLAW_CSUM);
    send_frame(want_seq, ~order_val, 16'(SHORT_REPLY_LEN), ack_val, FLAW_NONE);
    send_frame(want_seq + 16'h8001, order_val, 16'(SHORT_REPLY_LEN), ack_val, FLAW_NONE);
    send_frame(want_seq, order_val, 16'(CFG_REPLY_LEN), marker_val, FLAW_TAIL_CUT);
    send_frame(want_seq, order_val, 16'(CFG_REPLY_LEN), marker_val, FLAW_SHORT);
    send_frame(want_seq, order_val, 16'(SHORT_REPLY_LEN), ack_val, FLAW_EXTRA);
    send_beat(head_val, 1'b1);
  endtask

  // All registers at both extremes, then writes to indexes with no register.
  task automatic test_register_extremes();
    wait_results_done();
    write_all_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(want_seq, order_val, 16'(SHORT_REPLY_LEN), ack_val, FLAW_NONE);
    send_frame(want_seq, order_val, 16'(CFG_REPLY_LEN), marker_val, FLAW_NONE);
    wait_results_done();
    write_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(want_seq, order_val, 16'(SHORT_REPLY_LEN), ack_val, FLAW_NONE);
    send_frame(want_seq, order_val, 16'(CFG_REPLY_LEN), marker_val, FLAW_NONE);
    wait_results_done();
    write_reg(REG_SPARE_LO, 8'h00);
    write_reg(REG_SPARE_HI, 8'($urandom));
    send_frame(want_seq, order_val, 16'(SHORT_REPLY_LEN), ack_val, FLAW_NONE);
  endtask

  // Random traffic in chunks, each with its own register setting and idle rate.
  task automatic test_random_traffic();
    int chunk;
    int chunk_end;
    chunk = 0;
    while (beats_sent < TOTAL_BEATS - QUIET_BEATS) begin
      wait_results_done();
      case (chunk % 4)
        1:       write_all_regs(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
        3:       write_all_regs(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        default: write_all_regs(8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        2:       gap_pct = 25;
        default: gap_pct = 45;
      endcase
      chunk_end = beats_sent + CHUNK_BEATS;
      while (beats_sent < chunk_end) send_random_frame();
      chunk++;
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_quiet_finish();
    wait_results_done();
    gap_pct = 0;
    while (beats_sent < TOTAL_BEATS) send_random_frame();
  endtask

  // Result-side back-pressure in random bursts.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall == 0 && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
        stall = $urandom_range(1, 6);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare every result beat against the oldest predicted verdict.
  always @(posedge clk_i) begin
    verdict_t want;
    int       k;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        note_failure($sformatf("result with none expected: status=%0d data=%h",
                               m_axis_tuser, m_axis_tdata));
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tuser != want.status) begin
          note_failure($sformatf("status: expected %0d, got %0d", want.status, m_axis_tuser));
        end
        for (k = 0; k < CFG_COUNT; k++) begin
          if (m_axis_tdata[8*k +: 8] != want.cfg[k]) begin
            note_failure($sformatf("cfg_byte%0d: expected %h, got %h",
                                   k, want.cfg[k], m_axis_tdata[8*k +: 8]));
          end
        end
        if (m_axis_tdata[55:40] != want.next_seq) begin
          note_failure($sformatf("next_sequence: expected %h, got %h",
                                 want.next_seq, m_axis_tdata[55:40]));
        end
      end
    end
  end

  // Main sequence.
  initial begin
    head_val   = HEAD_BYTE_RESET;
    tail_val   = TAIL_BYTE_RESET;
    order_val  = REPLY_ORDER_RESET;
    ack_val    = ACK_CODE_RESET;
    marker_val = CONFIG_MARKER_RESET;
    cfg_bytes  = '0;
    want_seq   = '0;
    clear_parse();

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_registers();
    test_length_field();
    test_frame_faults();
    test_register_extremes();
    test_random_traffic();
    test_quiet_finish();

    wait_results_done();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
